FILE: rtl/assert_macros.svh
// Shared assertion macros, clocked on i_clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge.
`define SBFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must hold at every rising edge.
`define SBFD_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

FILE: rtl/sbfd_pkg.sv
`default_nettype none

package sbfd_pkg;

    localparam int unsigned MAX_PAYLOAD = 64;
    localparam int unsigned CNT_W       = $clog2(MAX_PAYLOAD) + 1;
    localparam int unsigned NUM_TYPES   = 4;
    localparam int unsigned CAP_NUM     = 20;

    localparam logic [2:0] MODE_IDLE = 3'd4;

    localparam logic [15:0] SYNC_WORDS [NUM_TYPES] = '{
        16'hFC3E, 16'hFC1F, 16'h2302, 16'hFD05
    };

    // Payload positions kept for the type-0 readings.
    localparam logic [CNT_W-1:0] CAP_POS [CAP_NUM] = '{
        CNT_W'(2),  CNT_W'(3),  CNT_W'(4),  CNT_W'(5),
        CNT_W'(6),  CNT_W'(7),  CNT_W'(8),  CNT_W'(9),
        CNT_W'(12), CNT_W'(13), CNT_W'(14), CNT_W'(15),
        CNT_W'(16), CNT_W'(20), CNT_W'(31), CNT_W'(32),
        CNT_W'(35), CNT_W'(36), CNT_W'(37), CNT_W'(38)
    };

    typedef struct packed {
        logic [1:0]          frame_type;
        logic                checksum_ok;
        logic signed [15:0]  collector_temp;
        logic signed [15:0]  tank_temp;
        logic signed [15:0]  supply_temp;
        logic signed [15:0]  outdoor_temp;
        logic signed [15:0]  return_temp;
        logic signed [15:0]  flow_rate;
        logic [7:0]          pump_pwm;
        logic [7:0]          status_code;
        logic signed [15:0]  energy_day;
        logic signed [31:0]  energy_total;
    } t_result;

    function automatic logic [CNT_W-1:0] frame_len(input logic [1:0] ftype);
        return CNT_W'(SYNC_WORDS[ftype][7:0]) + CNT_W'(1);
    endfunction

    function automatic logic [7:0] sync_sum(input logic [1:0] ftype);
        return SYNC_WORDS[ftype][15:8] + SYNC_WORDS[ftype][7:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/solar_bus_frame_decoder_top.sv
// Frame decoder for a solar controller serial bus. Takes one received byte per beat
// on the input channel and accepts a beat every cycle when not stalled; a result beat
// leaves after the byte that closes a frame (input register, then result register).
// Frames open on sync words FC3E, FC1F, 2302, FD05 (types 0 to 3) with 63, 32, 3 or
// 6 payload bytes; a sync word inside a payload drops the partial frame. Readings are
// filled only for type 0 with a good checksum, and are zero otherwise. Input stalls
// only while a finished result waits and the next byte would close another frame.
`default_nettype none

module solar_bus_frame_decoder_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic [7:0]   i_byte_value,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output logic [1:0]        o_frame_type,
    output logic              o_checksum_ok,
    output logic signed [15:0] o_collector_temp,
    output logic signed [15:0] o_tank_temp,
    output logic signed [15:0] o_supply_temp,
    output logic signed [15:0] o_outdoor_temp,
    output logic signed [15:0] o_return_temp,
    output logic signed [15:0] o_flow_rate,
    output logic [7:0]        o_pump_pwm,
    output logic [7:0]        o_status_code,
    output logic signed [15:0] o_energy_day,
    output logic signed [31:0] o_energy_total
);

    logic              in_valid;
    logic [7:0]        in_byte;
    logic              out_free;
    logic              res_valid;
    logic              step;
    sbfd_pkg::t_result res;
    sbfd_pkg::t_result out_res;

    assign step = in_valid && (!res_valid || out_free);

    sbfd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_byte_value),
        .i_step  (step),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    sbfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_result    (res)
    );

    sbfd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && res_valid),
        .i_result (res),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_res)
    );

    assign o_frame_type     = out_res.frame_type;
    assign o_checksum_ok    = out_res.checksum_ok;
    assign o_collector_temp = out_res.collector_temp;
    assign o_tank_temp      = out_res.tank_temp;
    assign o_supply_temp    = out_res.supply_temp;
    assign o_outdoor_temp   = out_res.outdoor_temp;
    assign o_return_temp    = out_res.return_temp;
    assign o_flow_rate      = out_res.flow_rate;
    assign o_pump_pwm       = out_res.pump_pwm;
    assign o_status_code    = out_res.status_code;
    assign o_energy_day     = out_res.energy_day;
    assign o_energy_total   = out_res.energy_total;

endmodule

`default_nettype wire

FILE: rtl/sbfd_in_stage.sv
`default_nettype none

module sbfd_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_step,
    output logic            o_valid,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_step;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sbfd_parser.sv
`default_nettype none

module sbfd_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_byte,
    output logic                 o_res_valid,
    output sbfd_pkg::t_result    o_result
);

    logic [15:0]                   r_shift;
    logic [2:0]                    r_mode;
    logic [sbfd_pkg::CNT_W-1:0]    r_count;
    logic [7:0]                    r_sum;
    logic [7:0]                    r_cap [sbfd_pkg::CAP_NUM];

    logic [15:0]                   n_shift;
    logic [2:0]                    n_mode;
    logic [sbfd_pkg::CNT_W-1:0]    n_count;
    logic [7:0]                    n_sum;

    logic                          sync_hit;
    logic [1:0]                    sync_type;
    logic                          in_frame;
    logic [1:0]                    cur_type;
    logic [sbfd_pkg::CNT_W-1:0]    cur_len;
    logic [sbfd_pkg::CNT_W-1:0]    cnt_inc;
    logic [7:0]                    sum_inc;
    logic                          last;
    logic                          good0;
    logic                          res_step;

    assign n_shift  = {r_shift[7:0], i_byte};
    assign in_frame = (r_mode != sbfd_pkg::MODE_IDLE);
    assign cur_type = r_mode[1:0];
    assign cur_len  = sbfd_pkg::frame_len(cur_type);
    assign cnt_inc  = r_count + sbfd_pkg::CNT_W'(1);
    assign sum_inc  = r_sum + i_byte;
    assign last     = in_frame && !sync_hit && (cnt_inc >= cur_len);

    always_comb begin
        sync_hit  = 1'b0;
        sync_type = 2'd0;
        for (int t = sbfd_pkg::NUM_TYPES - 1; t >= 0; t--) begin
            if (n_shift == sbfd_pkg::SYNC_WORDS[t]) begin
                sync_hit  = 1'b1;
                sync_type = 2'(t);
            end
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        n_sum   = r_sum;
        priority if (sync_hit) begin
            n_mode  = {1'b0, sync_type};
            n_count = '0;
            n_sum   = sbfd_pkg::sync_sum(sync_type);
        end else if (in_frame) begin
            n_count = cnt_inc;
            n_sum   = sum_inc;
            if (last) begin
                n_mode = sbfd_pkg::MODE_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_mode  <= sbfd_pkg::MODE_IDLE;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_step) begin
            r_shift <= n_shift;
            r_mode  <= n_mode;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && in_frame && !sync_hit) begin
            for (int k = 0; k < sbfd_pkg::CAP_NUM; k++) begin
                if (r_count == sbfd_pkg::CAP_POS[k]) begin
                    r_cap[k] <= i_byte;
                end
            end
        end
    end

    assign o_res_valid = last;
    assign good0       = (sum_inc == 8'd0) && (cur_type == 2'd0);
    assign res_step    = i_step && o_res_valid;

    always_comb begin
        o_result             = '0;
        o_result.frame_type  = cur_type;
        o_result.checksum_ok = (sum_inc == 8'd0);
        if (good0) begin
            o_result.collector_temp = {r_cap[1],  r_cap[0]};
            o_result.tank_temp      = {r_cap[3],  r_cap[2]};
            o_result.supply_temp    = {r_cap[5],  r_cap[4]};
            o_result.outdoor_temp   = {r_cap[7],  r_cap[6]};
            o_result.return_temp    = {r_cap[9],  r_cap[8]};
            o_result.flow_rate      = {r_cap[11], r_cap[10]};
            o_result.pump_pwm       = r_cap[12];
            o_result.status_code    = r_cap[13];
            o_result.energy_day     = {r_cap[15], r_cap[14]};
            o_result.energy_total   = {r_cap[19], r_cap[18], r_cap[17], r_cap[16]};
        end
    end

`include "assert_macros.svh"

    `SBFD_ASSERT(a_res_in_frame, res_step |-> in_frame, "result outside a frame")
    `SBFD_ASSERT(a_idle_after_res, res_step |=> (r_mode == sbfd_pkg::MODE_IDLE), "frame left open")
    `SBFD_ALWAYS(a_count_bound, !in_frame || (r_count < cur_len), "byte count past frame length")

endmodule

`default_nettype wire

FILE: rtl/sbfd_out_stage.sv
`default_nettype none

module sbfd_out_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire sbfd_pkg::t_result  i_result,
    output logic                    o_free,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output sbfd_pkg::t_result       o_result
);

    logic              r_valid;
    sbfd_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire
